### design/rc4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared widths, defaults and the permutation memory request type.
// ----------------------------------------------------------------------------
package rc4_pkg;

	localparam int ByteW         = 8;
	localparam int PermDepth     = 256;
	localparam int PermAw        = 8;
	localparam int KeyMaxDefault = 256;

	// one access group toward the permutation memory
	typedef struct packed {
		logic              rd_en;
		logic [PermAw-1:0] rd_addr;
		logic              wr_en;
		logic [PermAw-1:0] wr_addr;
		logic [ByteW-1:0]  wr_data;
		logic              clr;
	} perm_req_t;

endpackage
`default_nettype wire

### design/rc4_perm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_perm_ram
// 256 x 8 permutation memory, one read and one write port, registered read.
// Per-entry valid bits: an entry not written since the last clear reads as
// its own index, which gives the identity permutation without a fill sweep.
// ----------------------------------------------------------------------------
module rc4_perm_ram (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rc4_pkg::perm_req_t   req,
	output logic [rc4_pkg::ByteW-1:0] rd_data
);
	import rc4_pkg::*;

	logic [ByteW-1:0]     mem [PermDepth];
	logic [PermDepth-1:0] vld_q;
	logic [ByteW-1:0]     rd_q;
	logic                 rd_vld_q;
	logic [PermAw-1:0]    rd_addr_q;

	// read returns the old word when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			if (req.rd_en) begin
				rd_vld_q  <= vld_q[req.rd_addr];
				rd_addr_q <= req.rd_addr;
			end
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : ByteW'(rd_addr_q);

endmodule
`default_nettype wire

### design/rc4_key_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_key_ram
// Key byte store, one write and one registered read port.
// ----------------------------------------------------------------------------
module rc4_key_ram #(
	parameter int KEY_MAX = rc4_pkg::KeyMaxDefault,
	localparam int KeyAw  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [KeyAw-1:0]          wr_addr,
	input  logic [rc4_pkg::ByteW-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [KeyAw-1:0]          rd_addr,
	output logic [rc4_pkg::ByteW-1:0] rd_data
);
	import rc4_pkg::*;

	logic [ByteW-1:0] mem [KEY_MAX];
	logic [ByteW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

### design/rc4_stream_cipher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top
// RC4 engine: key loading, key schedule and keystream xor around a
// read-modify-write sequencer on the permutation memory.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     valid / ready          func, value, first, last
//  result    res_valid / res_ready  out_byte
//
//  key byte: taken without leaving the idle state, so ready stays high for the next word
//  data byte: steps set by the single memory read and write port, and no new word
//    is taken until all are done (read i, read j, write i and read s, write j);
//    result lands in an output register so the next word is taken while it waits
//  last key byte: key schedule of 256 rounds, each through sched read, P1, P2 and P3
//  reset gives the identity permutation at once through per-entry valid bits
//  a waiting result stalls only the final cycle of the following data byte
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top #(
	parameter int KEY_MAX = rc4_pkg::KeyMaxDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	output logic                      ready,
	input  logic                      func,
	input  logic [rc4_pkg::ByteW-1:0] value,
	input  logic                      first,
	input  logic                      last,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [rc4_pkg::ByteW-1:0] out_byte
);
	import rc4_pkg::*;

	localparam int KeyAw = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int CntW  = $clog2(KEY_MAX + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCHED_RD,
		ST_P1,
		ST_P2,
		ST_P3
	} state_t;

	state_t            state_q;
	logic              is_data_q;
	logic [PermAw-1:0] x_q;        // i or schedule round
	logic [PermAw-1:0] y_q;        // j or schedule accumulator
	logic [ByteW-1:0]  a_q;
	logic [ByteW-1:0]  b_q;
	logic [ByteW-1:0]  val_q;
	logic              s_eq_i_q;
	logic              s_eq_j_q;
	logic [PermAw-1:0] idx_i_q;
	logic [PermAw-1:0] idx_j_q;
	logic [CntW-1:0]   key_count_q;
	logic [KeyAw-1:0]  kidx_q;
	logic              res_valid_q;
	logic [ByteW-1:0]  out_byte_q;

	perm_req_t         perm_req;
	logic [ByteW-1:0]  perm_rd;
	logic [ByteW-1:0]  key_rd;

	logic              accept;
	logic              key_wr_en;
	logic [CntW-1:0]   cnt_eff;
	logic [PermAw-1:0] i_new;
	logic [CntW-1:0]   key_len;
	logic              kidx_wrap;
	logic [PermAw-1:0] y_next;
	logic [PermAw-1:0] s_addr;
	logic [ByteW-1:0]  ks;
	logic              out_stall;
	logic              res_load;

	assign ready     = (state_q == ST_IDLE);
	assign accept    = valid && ready;
	assign cnt_eff   = first ? '0 : key_count_q;
	assign key_wr_en = accept && !func && (cnt_eff < CntW'(KEY_MAX));
	assign i_new     = (first ? '0 : idx_i_q) + PermAw'(1);

	// a zero count acts as a one-byte key
	assign key_len   = (key_count_q == '0) ? CntW'(1) : key_count_q;
	assign kidx_wrap = (CntW'(kidx_q) + CntW'(1)) == key_len;

	assign y_next = is_data_q ? (idx_j_q + perm_rd) : (y_q + perm_rd + key_rd);
	assign s_addr = a_q + perm_rd;

	// perm[s] after the swap: the read of s returns the old word, so i and j come from b_q and a_q
	assign ks = s_eq_i_q ? b_q : (s_eq_j_q ? a_q : perm_rd);

	assign out_stall = is_data_q && res_valid_q && !res_ready;
	assign res_load  = (state_q == ST_P3) && is_data_q && !out_stall;

	always_comb begin
		perm_req = '0;
		case (state_q)
			ST_IDLE: begin
				perm_req.rd_en   = accept && func;
				perm_req.rd_addr = i_new;
				perm_req.clr     = accept && !func && last;
			end
			ST_SCHED_RD: begin
				perm_req.rd_en   = 1'b1;
				perm_req.rd_addr = x_q;
			end
			ST_P1: begin
				perm_req.rd_en   = 1'b1;
				perm_req.rd_addr = y_next;
			end
			ST_P2: begin
				perm_req.wr_en   = 1'b1;
				perm_req.wr_addr = x_q;
				perm_req.wr_data = perm_rd;
				perm_req.rd_en   = is_data_q;
				perm_req.rd_addr = s_addr;
			end
			ST_P3: begin
				perm_req.wr_en   = !out_stall;
				perm_req.wr_addr = y_q;
				perm_req.wr_data = a_q;
			end
			default: begin
				perm_req = '0;
			end
		endcase
	end

	rc4_perm_ram u_perm (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (perm_req),
		.rd_data (perm_rd)
	);

	rc4_key_ram #(
		.KEY_MAX (KEY_MAX)
	) u_key (
		.clk     (clk),
		.wr_en   (key_wr_en),
		.wr_addr (cnt_eff[KeyAw-1:0]),
		.wr_data (value),
		.rd_en   (state_q == ST_SCHED_RD),
		.rd_addr (kidx_q),
		.rd_data (key_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			is_data_q   <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			a_q         <= '0;
			b_q         <= '0;
			val_q       <= '0;
			s_eq_i_q    <= 1'b0;
			s_eq_j_q    <= 1'b0;
			idx_i_q     <= '0;
			idx_j_q     <= '0;
			key_count_q <= '0;
			kidx_q      <= '0;
			res_valid_q <= 1'b0;
			out_byte_q  <= '0;
		end else begin
			if (res_valid_q && res_ready && !res_load) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && func) begin
						is_data_q <= 1'b1;
						val_q     <= value;
						idx_i_q   <= i_new;
						x_q       <= i_new;
						if (first) begin
							idx_j_q <= '0;
						end
						state_q <= ST_P1;
					end else if (accept) begin
						key_count_q <= key_wr_en ? (cnt_eff + CntW'(1)) : cnt_eff;
						if (last) begin
							is_data_q <= 1'b0;
							x_q       <= '0;
							y_q       <= '0;
							kidx_q    <= '0;
							state_q   <= ST_SCHED_RD;
						end
					end
				end
				ST_SCHED_RD: begin
					state_q <= ST_P1;
				end
				ST_P1: begin
					a_q <= perm_rd;
					y_q <= y_next;
					if (is_data_q) begin
						idx_j_q <= y_next;
					end
					state_q <= ST_P2;
				end
				ST_P2: begin
					b_q      <= perm_rd;
					s_eq_i_q <= (s_addr == x_q);
					s_eq_j_q <= (s_addr == y_q);
					state_q  <= ST_P3;
				end
				ST_P3: begin
					if (is_data_q) begin
						if (!out_stall) begin
							res_valid_q <= 1'b1;
							out_byte_q  <= val_q ^ ks;
							state_q     <= ST_IDLE;
						end
					end else begin
						kidx_q <= kidx_wrap ? '0 : KeyAw'(kidx_q + KeyAw'(1));
						if (x_q == PermAw'(PermDepth - 1)) begin
							idx_i_q <= '0;
							idx_j_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							x_q     <= x_q + PermAw'(1);
							state_q <= ST_SCHED_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign out_byte  = out_byte_q;

endmodule
`default_nettype wire

### tb/rc4_stream_cipher_top_test.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top_test
// Self-checking bench for the RC4 engine. Key words and data words go in
// through a valid/ready sender with random gaps. A scoreboard keeps its own
// permutation, key store and indices, predicts every keystream byte and
// checks each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import rc4_pkg::*;

	localparam logic FuncKey  = 1'b0;
	localparam logic FuncData = 1'b1;

	localparam int ItemsTotal = 1020;
	localparam int IdleLimit  = 8000;
	localparam int TailCycles = 1100;

	// ------------------------------------------------------------------------
	// keystream predictor and result checker
	// ------------------------------------------------------------------------
	class rc4_scoreboard;
		logic [ByteW-1:0] perm [PermDepth];
		logic [ByteW-1:0] key_store [PermDepth];
		logic [8:0]       key_count;
		logic [ByteW-1:0] idx_i;
		logic [ByteW-1:0] idx_j;
		logic [ByteW-1:0] expected_bytes [$];
		int errors;
		int n_key;
		int n_data;
		int n_sched;
		int n_checked;
		int n_long_keys;

		function new();
			for (int n = 0; n < PermDepth; n++) begin
				perm[n]      = ByteW'(n);
				key_store[n] = '0;
			end
			key_count   = '0;
			idx_i       = '0;
			idx_j       = '0;
			errors      = 0;
			n_key       = 0;
			n_data      = 0;
			n_sched     = 0;
			n_checked   = 0;
			n_long_keys = 0;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void run_schedule();
			int len;
			logic [ByteW-1:0] acc;
			logic [ByteW-1:0] t;
			len = int'(key_count);
			acc = '0;
			if (len == 0)
				len = 1;
			for (int n = 0; n < PermDepth; n++)
				perm[n] = ByteW'(n);
			for (int n = 0; n < PermDepth; n++) begin
				acc = acc + perm[n] + key_store[n % len];
				t = perm[n];
				perm[n] = perm[acc];
				perm[acc] = t;
			end
			idx_i = '0;
			idx_j = '0;
			n_sched++;
		endfunction

		function void note_word(logic f, logic [ByteW-1:0] v, logic fs, logic ls);
			logic [ByteW-1:0] t;
			logic [ByteW-1:0] s;
			if (f == FuncKey) begin
				n_key++;
				if (fs)
					key_count = '0;
				if (key_count < 9'(KeyMaxDefault)) begin
					key_store[key_count[7:0]] = v;
					key_count = key_count + 9'd1;
				end else if (fs == 1'b0 && ls) begin
					n_long_keys++;
				end
				if (ls)
					run_schedule();
			end else begin
				n_data++;
				if (fs) begin
					idx_i = '0;
					idx_j = '0;
				end
				idx_i = idx_i + 8'd1;
				idx_j = idx_j + perm[idx_i];
				t = perm[idx_i];
				perm[idx_i] = perm[idx_j];
				perm[idx_j] = t;
				s = perm[idx_i] + perm[idx_j];
				expected_bytes.push_back(v ^ perm[s]);
			end
		endfunction

		task report(string msg);
			errors++;
			$display("%0t ns  mismatch: %s", $time, msg);
		endtask

		task check_byte(logic [ByteW-1:0] got);
			logic [ByteW-1:0] want;
			if (expected_bytes.size() == 0) begin
				report($sformatf("result word %02h with no data word pending", got));
			end else begin
				want = expected_bytes.pop_front();
				if (got !== want)
					report($sformatf("out_byte %02h, expected %02h (result %0d)",
						got, want, n_checked));
			end
			n_checked++;
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             valid;
	logic             ready;
	logic             func;
	logic [ByteW-1:0] value;
	logic             first;
	logic             last;
	logic             res_valid;
	logic             res_ready;
	logic [ByteW-1:0] out_byte;

	rc4_scoreboard sb = new();
	int n_items = 0;
	int idle_cycles = 0;

	rc4_stream_cipher_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.ready     (ready),
		.func      (func),
		.value     (value),
		.first     (first),
		.last      (last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_byte  (out_byte)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// sender side, always entered and left at a falling edge
	// ------------------------------------------------------------------------
	task send_word(input logic f, input logic [ByteW-1:0] v, input logic fs,
			input logic ls);
		int gap;
		gap = ((n_items % 150) < 25) ? 0 : int'($urandom_range(0, 14));
		if (gap > 0) begin
			valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		valid = 1'b1;
		func  = f;
		value = v;
		first = fs;
		last  = ls;
		do @(posedge clk); while (!ready);
		sb.note_word(f, v, fs, ls);
		n_items++;
		@(negedge clk);
	endtask

	task send_key(input int len);
		for (int k = 0; k < len; k++)
			send_word(FuncKey, 8'($urandom_range(0, 255)), k == 0, k == len - 1);
	endtask

	// last is don't-care on data words, so it is thrown in at random
	task send_message(input int len, input logic restart);
		for (int k = 0; k < len; k++)
			send_word(FuncData, 8'($urandom_range(0, 255)), restart && k == 0,
				$urandom_range(0, 3) == 0);
	endtask

	task wait_drained();
		valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int gap;
		int n_seen;
		n_seen = 0;
		res_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = ((n_seen % 128) < 24) ? 0 : int'($urandom_range(0, 14));
			if (gap > 0) begin
				res_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ready = 1'b1;
			do @(posedge clk); while (!res_valid);
			sb.check_byte(out_byte);
			n_seen++;
			@(negedge clk);
		end
	end

	// cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (valid && ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("%0t ns  timeout: no word moved for %0d cycles", $time, IdleLimit);
				$display("** rc4_stream_cipher_top: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int pick;
		arst_n = 1'b0;
		valid  = 1'b0;
		func   = FuncKey;
		value  = '0;
		first  = 1'b0;
		last   = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// keystream from the identity permutation left by reset
		send_word(FuncData, 8'h00, 1'b1, 1'b0);
		send_word(FuncData, 8'hff, 1'b0, 1'b1);
		send_word(FuncData, 8'h5a, 1'b0, 1'b0);
		// key words with no first right after reset append from zero
		send_word(FuncKey, 8'h00, 1'b0, 1'b0);
		send_word(FuncKey, 8'hff, 1'b0, 1'b1);
		send_word(FuncData, 8'hff, 1'b1, 1'b0);
		send_word(FuncData, 8'h00, 1'b0, 1'b0);
		send_word(FuncData, 8'ha5, 1'b0, 1'b1);
		// one-byte key
		send_word(FuncKey, 8'hff, 1'b1, 1'b1);
		send_word(FuncData, 8'h00, 1'b1, 1'b0);
		send_word(FuncData, 8'h00, 1'b0, 1'b0);
		// three-byte key, then a restart in the middle of a message
		send_word(FuncKey, 8'h01, 1'b1, 1'b0);
		send_word(FuncKey, 8'h02, 1'b0, 1'b0);
		send_word(FuncKey, 8'h03, 1'b0, 1'b1);
		send_word(FuncData, 8'h12, 1'b1, 1'b0);
		send_word(FuncData, 8'haa, 1'b0, 1'b0);
		send_word(FuncData, 8'h34, 1'b1, 1'b0);
		// one more byte appended to the stored key and scheduled again
		send_word(FuncKey, 8'h80, 1'b0, 1'b1);
		send_word(FuncData, 8'h7f, 1'b1, 1'b1);
		send_word(FuncData, 8'h80, 1'b0, 1'b0);
		wait_drained();

		// key past the store size: the tail is dropped, its last still schedules
		send_key(258);
		send_message(8, 1'b1);
		send_word(FuncKey, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
		send_message(8, 1'b1);

		while (n_items < ItemsTotal) begin
			pick = int'($urandom_range(0, 9));
			if (pick <= 6) begin
				send_key(($urandom_range(0, 7) == 0) ? int'($urandom_range(17, 64))
					: int'($urandom_range(1, 16)));
				repeat ($urandom_range(1, 3))
					send_message(int'($urandom_range(1, 24)), 1'b1);
			end else if (pick == 7) begin
				repeat ($urandom_range(1, 6))
					send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (pick == 8) begin
				// extend the current key, then carry on without first, from the indices the schedule reset
				send_word(FuncKey, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
				send_message(int'($urandom_range(1, 12)), 1'b0);
			end else begin
				wait_drained();
				send_message(int'($urandom_range(1, 24)), 1'b1);
			end
		end

		wait_drained();
		repeat (TailCycles) @(negedge clk);

		$display("run covered %0d key words, %0d data words and %0d key schedules,",
			sb.n_key, sb.n_data, sb.n_sched);
		$display("including %0d schedules on a saturated key; %0d result words checked",
			sb.n_long_keys, sb.n_checked);
		if (sb.errors == 0)
			$display("** rc4_stream_cipher_top: PASSED **");
		else
			$display("** rc4_stream_cipher_top: FAILED **");
		$finish;
	end

endmodule

### files.f
design/rc4_pkg.sv
design/rc4_perm_ram.sv
design/rc4_key_ram.sv
design/rc4_stream_cipher_top.sv
tb/rc4_stream_cipher_top_test.sv
